// ----- rtl/angle_rangefinder_distance_height_defines.svh -----
// Assertion macros used by the rangefinder divider RTL
`ifndef ANGLE_RANGEFINDER_DISTANCE_HEIGHT_DEFINES_SVH
`define ANGLE_RANGEFINDER_DISTANCE_HEIGHT_DEFINES_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("implication failed");
`define ASSERT_NEXT(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("next-cycle check failed");
`else
`define ASSERT_IMPL(lbl, clk, rst_n, a, c)
`define ASSERT_NEXT(lbl, clk, rst_n, a, c)
`endif
`endif

// ----- rtl/arfd_pkg.sv -----
// Types and constants of the angle rangefinder
package arfd_pkg;
  localparam int TERMS = 13;
  localparam int NUM_W = 62;
  localparam int DEN_W = 35;
  localparam logic [5:0] DIV_STEPS = 6'd62;
  localparam logic [5:0] MUL_STEPS = 6'd48;
  localparam logic [22:0] HGT_RST = 23'd98304;
  localparam logic [47:0] OUT_MAX = 48'hFFFF_FFFF_FFFF;

  typedef struct packed {
    logic [30:0] alpha;
    logic [30:0] beta;
  } in_t;

  typedef struct packed {
    logic [47:0] distance;
    logic [47:0] object_height;
    logic        saturated;
  } out_t;

  typedef struct packed {
    logic load;
    logic sel_beta;
    logic sq;
    logic cf_go;
    logic cf_upd;
    logic alpha_go;
    logic dist_upd;
    logic h_c;
    logic tb_go;
    logic tb_upd;
    logic mul_step;
    logic h_fin;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic k_last;
    logic alpha_zero;
    logic alpha_dist;
    logic beta_zero;
    logic mul_last;
    logic out_free;
  } sts_t;
endpackage

// ----- rtl/arfd_div.sv -----
// Restoring divider, one quotient bit per cycle
`include "angle_rangefinder_distance_height_defines.svh"
module arfd_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [arfd_pkg::NUM_W-1:0] num,
  input  logic [arfd_pkg::DEN_W-1:0] den,
  output logic                       done,
  output logic [arfd_pkg::NUM_W-1:0] quo
);
  import arfd_pkg::*;

  logic             run_r, done_r;
  logic [5:0]       cnt_r;
  logic [DEN_W-1:0] rem_r, den_r;
  logic [NUM_W-1:0] num_r;
  logic [DEN_W:0]   trial;
  logic [DEN_W+1:0] diff;
  logic             ge;

  // Trial subtraction of the shifted remainder
  assign trial = {rem_r, num_r[NUM_W-1]};
  assign diff  = {1'b0, trial} - {2'b00, den_r};
  assign ge    = ~diff[DEN_W+1];

  // Step control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= run_r && (cnt_r == 6'd1);
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= DIV_STEPS;
      end else if (run_r) begin
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd1) run_r <= 1'b0;
      end
    end
  end

  // Shift the numerator out and the quotient in
  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (run_r) begin
      rem_r <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      num_r <= {num_r[NUM_W-2:0], ge};
    end
  end

  assign done = done_r;
  assign quo  = num_r;

  `ASSERT_IMPL(a_start_idle, clk, rst_n, start, !run_r)
  `ASSERT_NEXT(a_done_pulse, clk, rst_n, done_r, !done_r)
  `ASSERT_NEXT(a_done_after_last, clk, rst_n, run_r && (cnt_r == 6'd1) && !start, done_r)
endmodule

// ----- rtl/arfd_dp.sv -----
// Datapath: angles, continued fraction terms, distance, height, output register
module arfd_dp (
  input  logic            clk,
  input  logic            rst_n,
  input  arfd_pkg::cmd_t  cmd,
  output arfd_pkg::sts_t  sts,
  input  arfd_pkg::in_t   in_data,
  input  logic            cfg_wr_en,
  input  logic [22:0]     cfg_wr_data,
  output logic            out_valid,
  input  logic            out_stall,
  output arfd_pkg::out_t  out_data
);
  import arfd_pkg::*;

  logic [22:0]      hgt_r;
  logic [30:0]      alpha_r, beta_r, x;
  logic [31:0]      xsq_r, q_r;
  logic [3:0]       k_r;
  logic [47:0]      dist_r, mq_r, h_r;
  logic             sat_r;
  logic [60:0]      tb_r;
  logic [108:0]     acc_r;
  logic [5:0]       mcnt_r;
  logic             out_valid_r;
  out_t             out_r;
  logic [61:0]      xx;
  logic [4:0]       kodd;
  logic signed [36:0] cfden_s;
  logic [DEN_W-1:0] cfden;
  logic signed [33:0] d_s;
  logic [32:0]      mag;
  logic [53:0]      cd;
  logic             div_start, div_done;
  logic [NUM_W-1:0] div_num, div_quo;
  logic [DEN_W-1:0] div_den;
  logic [78:0]      term;
  logic             tsat;
  logic [48:0]      hpos;

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) hgt_r <= HGT_RST;
    else if (cfg_wr_en) hgt_r <= cfg_wr_data;
  end

  // Continued fraction arithmetic
  assign x       = cmd.sel_beta ? beta_r : alpha_r;
  assign xx      = x * x;
  assign kodd    = {k_r, 1'b0} - 5'd1;
  assign cfden_s = $signed({2'b00, kodd, 30'd0}) - $signed({5'd0, q_r});
  assign cfden   = (cfden_s < $signed(37'h0_4000_0000)) ? 35'h0_4000_0000 : cfden_s[34:0];
  assign d_s     = $signed({4'b0001, 30'd0}) - $signed({2'b00, q_r});
  assign mag     = d_s[33] ? 33'(-d_s) : ((d_s == 34'sd0) ? 33'd1 : d_s[32:0]);
  assign cd      = hgt_r * d_s[30:0];

  // Divider request mux
  assign div_start = cmd.cf_go | (cmd.alpha_go & sts.alpha_dist) | cmd.tb_go;
  always_comb begin
    div_num = {xsq_r, 30'd0};
    div_den = cfden;
    if (cmd.alpha_go) begin
      div_num = {8'd0, cd};
      div_den = {4'd0, alpha_r};
    end else if (cmd.tb_go) begin
      div_num = {1'b0, beta_r, 30'd0};
      div_den = {2'b00, mag};
    end
  end

  arfd_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  // Height from the scaled product
  assign term = acc_r[108:30];
  assign tsat = |term[78:48];
  assign hpos = {1'b0, term[47:0]} + {26'd0, hgt_r};

  // Working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      alpha_r <= in_data.alpha;
      beta_r  <= in_data.beta;
      sat_r   <= 1'b0;
    end
    if (cmd.sq) begin
      xsq_r <= xx[61:30];
      q_r   <= '0;
      k_r   <= 4'(TERMS);
    end
    if (cmd.cf_upd) begin
      q_r <= div_quo[31:0];
      k_r <= k_r - 4'd1;
    end
    if (cmd.alpha_go) begin
      if (sts.alpha_zero) begin
        dist_r <= OUT_MAX;
        sat_r  <= 1'b1;
      end else if (!sts.alpha_dist) begin
        dist_r <= '0;
      end
    end
    if (cmd.dist_upd) begin
      if (|div_quo[61:48]) begin
        dist_r <= OUT_MAX;
        sat_r  <= 1'b1;
      end else begin
        dist_r <= div_quo[47:0];
      end
    end
    if (cmd.h_c) h_r <= {25'd0, hgt_r};
    if (cmd.tb_upd) begin
      tb_r   <= div_quo[60:0];
      acc_r  <= '0;
      mq_r   <= dist_r;
      mcnt_r <= MUL_STEPS;
    end
    if (cmd.mul_step) begin
      acc_r  <= {acc_r[107:0], 1'b0} + (mq_r[47] ? {48'd0, tb_r} : 109'd0);
      mq_r   <= {mq_r[46:0], 1'b0};
      mcnt_r <= mcnt_r - 6'd1;
    end
    if (cmd.h_fin) begin
      if (d_s[33]) begin
        h_r <= (tsat || term[47:0] >= {25'd0, hgt_r}) ? 48'd0
             : ({25'd0, hgt_r} - term[47:0]);
      end else if (tsat || hpos[48]) begin
        h_r   <= OUT_MAX;
        sat_r <= 1'b1;
      end else begin
        h_r <= hpos[47:0];
      end
    end
  end

  // Output register: drop on take, load when free
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (cmd.out_load) out_valid_r <= 1'b1;
    else if (!out_stall) out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_r.distance      <= dist_r;
      out_r.object_height <= h_r;
      out_r.saturated     <= sat_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Status to the controller
  assign sts.div_done   = div_done;
  assign sts.k_last     = (k_r == 4'd2);
  assign sts.alpha_zero = (alpha_r == 31'd0);
  assign sts.alpha_dist = (alpha_r != 31'd0) && !d_s[33] && (d_s != 34'sd0);
  assign sts.beta_zero  = (beta_r == 31'd0);
  assign sts.mul_last   = (mcnt_r == 6'd1);
  assign sts.out_free   = !out_valid_r || !out_stall;
endmodule

// ----- rtl/arfd_ctrl.sv -----
// Controller: sequences the continued fractions, divisions and product
module arfd_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  arfd_pkg::sts_t sts,
  output arfd_pkg::cmd_t cmd
);
  import arfd_pkg::*;

  typedef enum logic [11:0] {
    S_IDLE = 12'b0000_0000_0001,
    S_SQ   = 12'b0000_0000_0010,
    S_CFGO = 12'b0000_0000_0100,
    S_CFWT = 12'b0000_0000_1000,
    S_ALPH = 12'b0000_0001_0000,
    S_DWT  = 12'b0000_0010_0000,
    S_BCHK = 12'b0000_0100_0000,
    S_TBGO = 12'b0000_1000_0000,
    S_TBWT = 12'b0001_0000_0000,
    S_MUL  = 12'b0010_0000_0000,
    S_HFIN = 12'b0100_0000_0000,
    S_OUT  = 12'b1000_0000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic   beta_r, beta_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      beta_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      beta_r  <= beta_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt    = state_r;
    beta_nxt     = beta_r;
    cmd          = '0;
    cmd.sel_beta = beta_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          beta_nxt  = 1'b0;
          state_nxt = S_SQ;
        end
      end
      S_SQ: begin
        cmd.sq = 1'b1;
        if (TERMS < 2) state_nxt = beta_r ? S_TBGO : S_ALPH;
        else state_nxt = S_CFGO;
      end
      S_CFGO: begin
        cmd.cf_go = 1'b1;
        state_nxt = S_CFWT;
      end
      S_CFWT: begin
        if (sts.div_done) begin
          cmd.cf_upd = 1'b1;
          if (sts.k_last) state_nxt = beta_r ? S_TBGO : S_ALPH;
          else state_nxt = S_CFGO;
        end
      end
      S_ALPH: begin
        cmd.alpha_go = 1'b1;
        state_nxt    = sts.alpha_dist ? S_DWT : S_BCHK;
      end
      S_DWT: begin
        if (sts.div_done) begin
          cmd.dist_upd = 1'b1;
          state_nxt    = S_BCHK;
        end
      end
      S_BCHK: begin
        if (sts.beta_zero) begin
          cmd.h_c   = 1'b1;
          state_nxt = S_OUT;
        end else begin
          beta_nxt  = 1'b1;
          state_nxt = S_SQ;
        end
      end
      S_TBGO: begin
        cmd.tb_go = 1'b1;
        state_nxt = S_TBWT;
      end
      S_TBWT: begin
        if (sts.div_done) begin
          cmd.tb_upd = 1'b1;
          state_nxt  = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul_step = 1'b1;
        if (sts.mul_last) state_nxt = S_HFIN;
      end
      S_HFIN: begin
        // Settle the height from the finished product
        cmd.h_fin = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        // Height is settled on entry
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign in_stall = (state_r != S_IDLE);
endmodule

// ----- rtl/angle_rangefinder_distance_height.sv -----
// Top level of the angle rangefinder: distance and object height
// One request at a time: a request holds alpha and beta (Q1.30 radians) and
// yields distance and object height in Q32.16 with a saturation flag. All
// work goes through one shared restoring divider of 62 steps: 12 continued
// fraction divisions per angle, one for the distance and one for tan(beta),
// plus a 48-step shift-add product for the height. The next request is
// taken once the result sits in the output register; the instrument height
// is to be written through cfg_wr_en and cfg_wr_data only while the block
// is idle, which the block itself does not enforce.
module angle_rangefinder_distance_height (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  arfd_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output arfd_pkg::out_t out_data,
  input  logic           cfg_wr_en,
  input  logic [22:0]    cfg_wr_data
);
  import arfd_pkg::*;

  cmd_t cmd;
  sts_t sts;

  arfd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  arfd_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .in_data     (in_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );
endmodule

// ----- tb/sv/tb_top.sv -----
// Testbench for the angle rangefinder: distance and object height per request
`timescale 1ns / 100ps

module tb_top;
  import arfd_pkg::*;

  localparam logic [63:0] ONE_Q30     = 64'd1 << 30;
  localparam int          CYCLE_LIMIT = 4_000_000;
  localparam int          SETTLE      = 2000;

  logic           clk;
  logic           rst_n;
  logic           in_valid;
  logic           in_stall;
  in_t            in_data;
  logic           out_valid;
  logic           out_stall;
  out_t           out_data;
  logic           cfg_wr_en;
  logic [22:0]    cfg_wr_data;

  logic [22:0]    inst_height;
  out_t           pending_q[$];
  int             n_fail;
  int             n_sent;
  int             n_recv;
  int             n_sat;
  int             n_cfg;
  int             cycles;

  angle_rangefinder_distance_height DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Final denominator 1 + s of the backward continued fraction, signed Q.30
  function automatic logic signed [63:0] cf_denom(logic [63:0] x);
    logic [63:0]        xsq;
    logic signed [63:0] s;
    logic signed [63:0] den;
    logic [63:0]        q;
    xsq = (x * x) >> 30;
    s = '0;
    for (int k = TERMS; k >= 2; k--) begin
      den = $signed((2 * k - 1) * ONE_Q30) + s;
      if (den < $signed(ONE_Q30)) den = $signed(ONE_Q30);
      q = (xsq << 30) / $unsigned(den);
      s = -$signed(q);
    end
    return $signed(ONE_Q30) + s;
  endfunction

  // Distance and object height for one request at the current instrument height
  function automatic out_t range_height(in_t req, logic [22:0] hgt);
    out_t               r;
    logic [63:0]        c;
    logic [63:0]        dist_v;
    logic [63:0]        mag;
    logic [63:0]        tb;
    logic [127:0]       prod;
    logic [63:0]        term;
    logic [63:0]        h;
    logic signed [63:0] da;
    logic signed [63:0] db;
    logic               tsat;
    c = {41'd0, hgt};
    r.saturated = 1'b0;
    if (req.alpha == 0) begin
      dist_v = {16'd0, OUT_MAX};
      r.saturated = 1'b1;
    end else begin
      da = cf_denom({33'd0, req.alpha});
      if (da <= 0) begin
        dist_v = 64'd0;
      end else begin
        dist_v = (c * $unsigned(da)) / {33'd0, req.alpha};
        if (dist_v > {16'd0, OUT_MAX}) begin
          dist_v = {16'd0, OUT_MAX};
          r.saturated = 1'b1;
        end
      end
    end
    if (req.beta == 0) begin
      h = c;
    end else begin
      db = cf_denom({33'd0, req.beta});
      mag = (db < 0) ? $unsigned(-db) : $unsigned(db);
      if (mag == 0) mag = 64'd1;
      tb = ({33'd0, req.beta} << 30) / mag;
      prod = ({64'd0, tb} * {64'd0, dist_v}) >> 30;
      tsat = prod > {80'd0, OUT_MAX};
      term = tsat ? {16'd0, OUT_MAX} : prod[63:0];
      if (db >= 0) begin
        h = c + term;
        if (tsat || h > {16'd0, OUT_MAX}) begin
          h = {16'd0, OUT_MAX};
          r.saturated = 1'b1;
        end
      end else begin
        h = (term >= c) ? 64'd0 : c - term;
      end
    end
    r.distance = dist_v[47:0];
    r.object_height = h[47:0];
    return r;
  endfunction

  // Offer one request and hold it until taken; valid stays high afterwards
  task automatic offer(in_t req, bit typed, out_t typed_res);
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (in_stall);
    pending_q.push_back(typed ? typed_res : range_height(req, inst_height));
    n_sent++;
  endtask

  task automatic pause_sender();
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Angle across the whole field, weighted towards tiny and in-range values
  function automatic logic [30:0] rand_angle(bit allow_zero);
    logic [30:0] a;
    case ($urandom_range(0, 9))
      0:       a = 31'($urandom_range(0, 2000));
      1, 2:    a = 31'($urandom());
      3:       a = 31'($urandom_range(1_686_629_713, 1_686_629_713 + 200));
      default: a = 31'($urandom_range(1, 1_503_238_553));
    endcase
    if (!allow_zero && a == 0) a = 31'd1;
    return a;
  endfunction

  task automatic random_requests(int n);
    in_t req;
    out_t unused;
    unused = '0;
    for (int i = 0; i < n; i++) begin
      req.alpha = ($urandom_range(0, 40) == 0) ? 31'd0 : rand_angle(1'b0);
      req.beta = ($urandom_range(0, 7) == 0) ? 31'd0 : rand_angle(1'b1);
      offer(req, 1'b0, unused);
      pause_sender();
    end
    in_valid <= 1'b0;
  endtask

  // Wait for the block to drain, then write the instrument height
  task automatic set_height(logic [22:0] v);
    while (pending_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    inst_height = v;
    n_cfg++;
  endtask

  // Receiver stall pattern, with one long hold-off to back up the input
  initial begin
    int run;
    bit held;
    out_stall <= 1'b0;
    held = 1'b0;
    @(posedge rst_n);
    forever begin
      if (!held && n_recv >= 60) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (6000) @(posedge clk);
      end
      run = $urandom_range(1, 30);
      out_stall <= ($urandom_range(0, 2) == 0);
      repeat (run) @(posedge clk);
    end
  end

  // Compare each taken result with the oldest expectation
  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_q.size() == 0) begin
        $error("result with no request outstanding");
        n_fail++;
      end else begin
        want = pending_q.pop_front();
        n_recv++;
        if (out_data.saturated) n_sat++;
        if (out_data.distance !== want.distance) begin
          $error("distance: expected %0d, got %0d", want.distance, out_data.distance);
          n_fail++;
        end
        if (out_data.object_height !== want.object_height) begin
          $error("object_height: expected %0d, got %0d",
                 want.object_height, out_data.object_height);
          n_fail++;
        end
        if (out_data.saturated !== want.saturated) begin
          $error("saturated: expected %0b, got %0b", want.saturated, out_data.saturated);
          n_fail++;
        end
      end
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Directed requests first, then random phases at several instrument heights
  initial begin
    in_t  dir_req[$];
    bit   dir_typed[$];
    out_t dir_res[$];
    out_t typed_res;
    in_t  req;
    n_fail = 0; n_sent = 0; n_recv = 0; n_sat = 0; n_cfg = 0; cycles = 0;
    inst_height = HGT_RST;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_wr_en <= 1'b0;
    cfg_wr_data <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // alpha zero, no beta: distance clipped, height is the default 1.5 m
    dir_req.push_back('{alpha: 31'd0, beta: 31'd0}); dir_typed.push_back(1);
    dir_res.push_back('{distance: OUT_MAX, object_height: 48'd98304, saturated: 1'b1});
    // alpha zero with a steep beta: height clipped too
    dir_req.push_back('{alpha: 31'd0, beta: 31'd1503238553}); dir_typed.push_back(1);
    dir_res.push_back('{distance: OUT_MAX, object_height: OUT_MAX, saturated: 1'b1});
    // alpha past pi/2, no beta: distance zero, no flag
    dir_req.push_back('{alpha: 31'h7FFF_FFFF, beta: 31'd0}); dir_typed.push_back(1);
    dir_res.push_back('{distance: 48'd0, object_height: 48'd98304, saturated: 1'b0});
    dir_req.push_back('{alpha: 31'd1, beta: 31'd0}); dir_typed.push_back(0);
    dir_req.push_back('{alpha: 31'd1, beta: 31'd1}); dir_typed.push_back(0);
    dir_req.push_back('{alpha: 31'd1503238553, beta: 31'd1503238553}); dir_typed.push_back(0);
    dir_req.push_back('{alpha: 31'd843314857, beta: 31'd1073741824}); dir_typed.push_back(0);
    dir_req.push_back('{alpha: 31'd1073741824, beta: 31'd536870912}); dir_typed.push_back(0);
    // around pi/2 for alpha and beta: sign change of the denominator
    dir_req.push_back('{alpha: 31'd1686629713, beta: 31'd1686629713}); dir_typed.push_back(0);
    dir_req.push_back('{alpha: 31'd1686629700, beta: 31'd1686629730}); dir_typed.push_back(0);
    dir_req.push_back('{alpha: 31'd1073741824, beta: 31'h7FFF_FFFF}); dir_typed.push_back(0);
    dir_req.push_back('{alpha: 31'd1073741824, beta: 31'd1800000000}); dir_typed.push_back(0);
    dir_req.push_back('{alpha: 31'd1200000000, beta: 31'd1686629720}); dir_typed.push_back(0);
    dir_req.push_back('{alpha: 31'd1000, beta: 31'd1400000000}); dir_typed.push_back(0);
    dir_req.push_back('{alpha: 31'h5555_5555, beta: 31'h2AAA_AAAA}); dir_typed.push_back(0);
    for (int i = 0; i < dir_req.size(); i++) begin
      typed_res = dir_typed[i] ? dir_res[0] : '0;
      if (dir_typed[i]) void'(dir_res.pop_front());
      offer(dir_req[i], dir_typed[i], typed_res);
      pause_sender();
    end
    random_requests(60);

    set_height(23'd1);
    req = '{alpha: 31'd0, beta: 31'd0};
    offer(req, 1'b1, '{distance: OUT_MAX, object_height: 48'd1, saturated: 1'b1});
    random_requests(90);
    set_height(23'd6553600);
    random_requests(90);
    set_height(23'h7F_FFFF);
    random_requests(80);
    set_height(23'($urandom_range(1, 6553600)));
    random_requests(80);

    // Drain, then allow the block's latency for stray results
    while (pending_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    $display("Covered %0d requests over %0d height settings, %0d results checked",
             n_sent, n_cfg + 1, n_recv);
    $display("%0d results flagged saturated; receiver held off once for 6000 cycles", n_sat);
    if (n_fail == 0 && pending_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
